/* hw/rtl/fit_block_allocator_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the fit block allocator checker.
// ---------------------------------------------------------------------------
`ifndef FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fit_block_allocator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fit_block_allocator: next-cycle check failed");

`endif

/* hw/rtl/fba_pkg.sv */
// ---------------------------------------------------------------------------
// fba_pkg
// Shared types and constants of the fit block allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fba_pkg;

	localparam int DEF_NUM_BLOCKS = 16;
	localparam int DEF_SIZE_BITS  = 16;

	localparam int PADDR_W = 3;

	// register index, taken from paddr[2]
	localparam logic REG_FIT_POLICY    = 1'b0;
	localparam logic REG_BLOCKS_IN_USE = 1'b1;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	localparam logic [4:0] BLOCKS_IN_USE_RST = 5'd16;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_ALLOC = 1'b1;

	typedef struct packed {
		logic        func;
		logic [3:0]  load_index;
		logic [15:0] load_size;
		logic [15:0] request_size;
	} in_item_t;

	typedef struct packed {
		logic       was_request;
		logic       granted;
		logic [3:0] block_index;
	} out_item_t;

endpackage

/* hw/rtl/fit_block_allocator.sv */
// ---------------------------------------------------------------------------
// fit_block_allocator
// Block size table with first, best or worst fit allocation over one
// shared compare unit.
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake             payload
//  -------  ---  --------------------  ------------------------------------
//  in       in   in_valid / in_stall   in_data  (func, index, sizes)
//  out      out  out_valid / out_stall out_data (was_request, granted, idx)
//  apb      in   psel/penable/pready   fit_policy @0x0, blocks_in_use @0x4
//
//  A load goes from ST_IDLE straight to ST_DONE. A request scans the first
//  min(blocks_in_use, NUM_BLOCKS) blocks (none for an empty window): the
//  size memory read port visits one block per cycle and the comparator
//  judges it the cycle after.
//  One item at a time; in_stall is high until the result is in the output
//  register. A stalled result waits there while the next item is taken.
//  Reset clears the table to zero size and no block used at once, through
//  one loaded bit and one used bit per block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fit_block_allocator #(
	parameter int NUM_BLOCKS = fba_pkg::DEF_NUM_BLOCKS,
	parameter int SIZE_BITS  = fba_pkg::DEF_SIZE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  fba_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output fba_pkg::out_item_t         out_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fba_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import fba_pkg::*;

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
	localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;

	// sequencer
	localparam logic [1:0] ST_IDLE = 2'd0;	// waiting for a transfer
	localparam logic [1:0] ST_SCAN = 2'd1;	// walking the table
	localparam logic [1:0] ST_FIN  = 2'd2;	// build result, mark block used
	localparam logic [1:0] ST_DONE = 2'd3;	// hand result to output register

	logic [1:0] state_q;

	// configuration
	logic [1:0] fit_policy_q;
	logic [4:0] blocks_in_use_q;

	// table
	logic [SIZE_BITS-1:0] size_mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] loaded_q;
	logic [NUM_BLOCKS-1:0] used_q;

	// scan
	logic [IDX_W-1:0]     issue_idx_q;
	logic [IDX_W-1:0]     last_idx_q;
	logic                 issuing_q;
	logic                 rd_valid_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic                 rd_loaded_s1;
	logic [SIZE_BITS-1:0] rd_data_s1;
	logic [SIZE_BITS-1:0] need_q;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] best_q;

	out_item_t res_q;
	out_item_t out_data_q;
	logic      out_valid_q;

	logic                 in_xfer;
	logic                 load_hit;
	logic [IDX_W-1:0]     load_idx;
	logic [LIM_W-1:0]     lim;
	logic                 mem_we;
	logic                 mem_re;
	logic [SIZE_BITS-1:0] cand_size;
	logic                 cand_fits;
	logic                 cand_better;
	logic                 cand_take;
	logic                 cfg_wr;
	logic                 out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || !out_stall;

	// ---- configuration port ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_FIT_POLICY:    prdata = 32'(fit_policy_q);
			REG_BLOCKS_IN_USE: prdata = 32'(blocks_in_use_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q    <= POL_FIRST;
			blocks_in_use_q <= BLOCKS_IN_USE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FIT_POLICY:    fit_policy_q    <= pwdata[1:0];
				REG_BLOCKS_IN_USE: blocks_in_use_q <= pwdata[4:0];
				default:           ;
			endcase
		end
	end

	// ---- request window: blocks_in_use clamped to the table ----
	always_comb begin
		lim = LIM_W'(blocks_in_use_q);
		if (lim > LIM_W'(NUM_BLOCKS))
			lim = LIM_W'(NUM_BLOCKS);
	end

	// loads beyond the table are acknowledged but change nothing
	assign load_hit = (int'(in_data.load_index) < NUM_BLOCKS);
	assign load_idx = IDX_W'(in_data.load_index);

	// ---- size memory: one write port, one registered read port ----
	assign mem_we = in_xfer && (in_data.func == FUNC_LOAD) && load_hit;
	assign mem_re = (state_q == ST_SCAN) && issuing_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			size_mem[load_idx] <= SIZE_BITS'(in_data.load_size);
		if (mem_re)
			rd_data_s1 <= size_mem[issue_idx_q];
	end

	// ---- shared compare unit ----
	assign cand_size = rd_loaded_s1 ? rd_data_s1 : '0;
	assign cand_fits = !used_q[rd_idx_s1] && (cand_size >= need_q);

	always_comb begin
		cand_better = 1'b0;
		priority if (!found_q)
			cand_better = 1'b1;
		else if (fit_policy_q == POL_BEST)
			cand_better = (cand_size < best_q);
		else if (fit_policy_q == POL_WORST)
			cand_better = (cand_size > best_q);
		else
			cand_better = 1'b0;	// first fit keeps its first find
	end

	assign cand_take = rd_valid_s1 && cand_fits && cand_better;

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			loaded_q     <= '0;
			used_q       <= '0;
			issue_idx_q  <= '0;
			last_idx_q   <= '0;
			issuing_q    <= 1'b0;
			rd_valid_s1  <= 1'b0;
			rd_loaded_s1 <= 1'b0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= mem_re;
			if (mem_re)
				rd_loaded_s1 <= loaded_q[issue_idx_q];

			// output register: filled on hand-over, emptied by its transfer
			if ((state_q == ST_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (in_data.func == FUNC_LOAD) begin
							if (load_hit) begin
								loaded_q[load_idx] <= 1'b1;
								used_q[load_idx]   <= 1'b0;
							end
							state_q <= ST_DONE;
						end else begin
							found_q     <= 1'b0;
							issue_idx_q <= '0;
							last_idx_q  <= IDX_W'(lim - LIM_W'(1));
							issuing_q   <= (lim != '0);
							state_q     <= (lim != '0) ? ST_SCAN : ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (issuing_q) begin
						if (issue_idx_q == last_idx_q)
							issuing_q <= 1'b0;
						else
							issue_idx_q <= issue_idx_q + IDX_W'(1);
					end
					if (cand_take)
						found_q <= 1'b1;
					if (rd_valid_s1 && (rd_idx_s1 == last_idx_q))
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (found_q)
						used_q[pick_q] <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (mem_re)
			rd_idx_s1 <= issue_idx_q;
		if (in_xfer) begin
			need_q <= SIZE_BITS'(in_data.request_size);
			if (in_data.func == FUNC_LOAD) begin
				res_q.was_request <= 1'b0;
				res_q.granted     <= 1'b0;
				res_q.block_index <= in_data.load_index;
			end
		end
		if (cand_take) begin
			pick_q <= rd_idx_s1;
			best_q <= cand_size;
		end
		if (state_q == ST_FIN) begin
			res_q.was_request <= 1'b1;
			res_q.granted     <= found_q;
			res_q.block_index <= found_q ? 4'(pick_q) : 4'd0;
		end
		if ((state_q == ST_DONE) && out_free)
			out_data_q <= res_q;
	end

endmodule

/* hw/rtl/fba_checker.sv */
// ---------------------------------------------------------------------------
// fba_checker
// Port-level checks on the fit block allocator, bound to its top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fit_block_allocator_assert.svh"

module fba_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input fba_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input fba_pkg::out_item_t out_data
);
	import fba_pkg::*;

	// a held result keeps its transfer pending
	`FBA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// a held result does not change
	`FBA_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_data))

	// one item at a time: busy right after a transfer in
	`FBA_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall)

	// a refused request reports block zero; a load acknowledge never grants
	`FBA_ASSERT_IMPLY(a_refuse, clk, arst_n, out_valid && !out_data.granted,
		(out_data.block_index == 4'd0) || !out_data.was_request)
	`FBA_ASSERT_IMPLY(a_ack, clk, arst_n, out_valid && !out_data.was_request,
		!out_data.granted)

endmodule

bind fit_block_allocator fba_checker u_fba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
